FILE: rtl/core/periodic_task_release_scheduler_assert.svh
// Assertion macros for the periodic task release scheduler.
`ifndef PERIODIC_TASK_RELEASE_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_RELEASE_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS

`define PTRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define PTRS_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define PTRS_ASSERT(label, clk, rst, prop, msg)

`define PTRS_NEVER(label, clk, rst, expr, msg)

`endif

`endif

FILE: rtl/core/ptrs_pkg.sv
// Shared types and constants of the periodic task release scheduler.
package ptrs_pkg;

   localparam int NumSlots  = 8;
   localparam int SlotW     = (NumSlots > 1) ? $clog2(NumSlots) : 1;
   localparam int MaskBits  = 8;
   localparam int PeriodW   = 16;
   localparam int StepW     = $clog2(PeriodW);

   localparam logic [2:0] REQ_TICK    = 3'd0;
   localparam logic [2:0] REQ_CREATE  = 3'd1;
   localparam logic [2:0] REQ_DELETE  = 3'd2;
   localparam logic [2:0] REQ_SUSPEND = 3'd3;
   localparam logic [2:0] REQ_RESUME  = 3'd4;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [7:0]         slot;
      logic [PeriodW-1:0] period;
   } req_item_type;

   typedef struct packed {
      logic [MaskBits-1:0] due_mask;
      logic [PeriodW-1:0]  tick_count;
      logic                request_done;
   } rsp_item_type;

endpackage

FILE: rtl/core/ptrs_if.sv
// Valid/ready channels carrying request and response items.
interface ptrs_req_if;
   ptrs_pkg::req_item_type data;
   logic                   valid;
   logic                   ready;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ptrs_rsp_if;
   ptrs_pkg::rsp_item_type data;
   logic                   valid;
   logic                   ready;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/periodic_task_release_scheduler.sv
// Periodic task release scheduler: slot table, tick counter, bit-serial release walk.
//
// Channels: req carries one item per request (tick, create, delete, suspend,
// resume); rsp returns exactly one item per request with the release mask,
// the tick counter after the request and a done flag.
// One request is worked on at a time; req.ready is high only when idle.
// Slot management passes from acceptance to ST_FIN, which loads the response
// register once the output register is free and then returns to idle.
// A tick walks the slots through one shared bit-serial remainder unit: a
// slot that cannot fire is just stepped past, while an armed slot takes a load
// in ST_WALK and 16 remainder steps in ST_DIV, one quotient bit per cycle.
// The response sits in an output register, so a stalled receiver does not
// block finishing the next request; only loading a new response waits.
// Synchronous reset empties all slots, clears the counter and drops rsp.valid.
module periodic_task_release_scheduler (
   input logic       clock,
   input logic       reset,
   ptrs_req_if.sink   req,
   ptrs_rsp_if.source rsp
);
   import ptrs_pkg::*;

   `include "periodic_task_release_scheduler_assert.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [PeriodW-1:0]  period_ff [NumSlots];
   logic [PeriodW-1:0]  period_in [NumSlots];
   logic [NumSlots-1:0] present_ff, present_in;
   logic [NumSlots-1:0] susp_ff, susp_in;
   logic [PeriodW-1:0]  tick_ff, tick_in;
   logic [SlotW-1:0]    idx_ff, idx_in;
   logic [StepW-1:0]    step_ff, step_in;
   logic [PeriodW-1:0]  rem_ff, rem_in;
   logic [PeriodW-1:0]  div_ff, div_in;
   logic [MaskBits-1:0] mask_ff, mask_in;
   logic                done_ff, done_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                in_range;
   logic [SlotW-1:0]    req_idx;
   logic [PeriodW-1:0]  per_cur;
   logic                armed;
   logic                last_slot;
   logic [PeriodW:0]    rem_shift;
   logic [PeriodW:0]    rem_sub;
   logic [PeriodW-1:0]  rem_next;
   logic [MaskBits-1:0] hit_bit;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign in_range  = (req.data.slot < 8'(NumSlots));
   assign req_idx   = req.data.slot[SlotW-1:0];

   assign per_cur   = period_ff[idx_ff];
   assign armed     = present_ff[idx_ff] && !susp_ff[idx_ff] && (per_cur != '0);
   assign last_slot = (idx_ff == SlotW'(NumSlots - 1));

   // restoring remainder step, one dividend bit per cycle
   assign rem_shift = {rem_ff, div_ff[PeriodW-1]};
   assign rem_sub   = rem_shift - {1'b0, per_cur};
   assign rem_next  = rem_sub[PeriodW] ? rem_shift[PeriodW-1:0] : rem_sub[PeriodW-1:0];
   assign hit_bit   = (32'(idx_ff) < MaskBits) ? (MaskBits'(1) << idx_ff) : '0;

   always_comb begin
      state_in     = state_ff;
      period_in    = period_ff;
      present_in   = present_ff;
      susp_in      = susp_ff;
      tick_in      = tick_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      mask_in      = mask_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mask_in = '0;
               done_in = 1'b0;
               state_in = ST_FIN;
               priority if (req.data.req_type == REQ_TICK) begin
                  tick_in  = tick_ff + 1'b1;
                  done_in  = 1'b1;
                  idx_in   = '0;
                  state_in = ST_WALK;
               end else if (in_range) begin
                  unique case (req.data.req_type)
                     REQ_CREATE: begin
                        if (!present_ff[req_idx]) begin
                           period_in[req_idx]  = req.data.period;
                           present_in[req_idx] = 1'b1;
                           susp_in[req_idx]    = 1'b0;
                           done_in             = 1'b1;
                        end
                     end
                     REQ_DELETE: begin
                        period_in[req_idx]  = '0;
                        present_in[req_idx] = 1'b0;
                        susp_in[req_idx]    = 1'b0;
                        done_in             = 1'b1;
                     end
                     REQ_SUSPEND: begin
                        susp_in[req_idx] = 1'b1;
                        done_in          = 1'b1;
                     end
                     REQ_RESUME: begin
                        susp_in[req_idx] = 1'b0;
                        done_in          = 1'b1;
                     end
                     default: begin
                        done_in = 1'b0;
                     end
                  endcase
               end else begin
                  done_in = 1'b0;
               end
            end
         end
         ST_WALK: begin
            if (armed) begin
               rem_in   = '0;
               div_in   = tick_ff;
               step_in  = '0;
               state_in = ST_DIV;
            end else if (last_slot) begin
               state_in = ST_FIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DIV: begin
            rem_in  = rem_next;
            div_in  = {div_ff[PeriodW-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == StepW'(PeriodW - 1)) begin
               if (rem_next == '0) begin
                  mask_in = mask_ff | hit_bit;
               end
               if (last_slot) begin
                  state_in = ST_FIN;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_WALK;
               end
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.due_mask     = mask_ff;
               rsp_data_in.tick_count   = tick_ff;
               rsp_data_in.request_done = done_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         present_ff   <= '0;
         susp_ff      <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NumSlots; i++) begin
            period_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         susp_ff      <= susp_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
         period_ff    <= period_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      step_ff     <= step_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      mask_ff     <= mask_in;
      done_ff     <= done_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   `PTRS_ASSERT(a_div_only_armed, clock, reset, (state_ff == ST_DIV) |-> armed, "remainder walk on a slot that cannot fire")
   `PTRS_ASSERT(a_tick_only_on_tick, clock, reset, !(accept && (req.data.req_type == REQ_TICK)) |=> $stable(tick_ff), "tick counter moved without a tick")
   `PTRS_NEVER(a_mask_needs_done, clock, reset, rsp_valid_ff && !rsp_data_ff.request_done && (rsp_data_ff.due_mask != '0), "release mask on a request that did not take effect")

endmodule

FILE: bench/release_schedule_checker.sv
// Scoreboard for the scheduler: predicts every response item and compares it with the DUT.
`timescale 1ns / 1ps
module release_schedule_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  ptrs_pkg::req_item_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ptrs_pkg::rsp_item_type rsp_data,
   output int                     mismatch_count,
   output int                     outstanding_count
);
   import ptrs_pkg::*;

   logic [PeriodW-1:0] task_period    [NumSlots];
   logic               task_present   [NumSlots];
   logic               slot_paused    [NumSlots];
   logic [PeriodW-1:0] tick_value;
   rsp_item_type       awaited_rsp [$];

   function automatic rsp_item_type apply_request(input req_item_type item);
      rsp_item_type result;
      result = '0;
      if (item.req_type == REQ_TICK) begin
         tick_value = tick_value + 1'b1;
         for (int i = 0; i < NumSlots; i++) begin
            if (i < MaskBits && task_present[i] && !slot_paused[i]
                && task_period[i] != '0 && (tick_value % task_period[i]) == '0) begin
               result.due_mask[i] = 1'b1;
            end
         end
         result.request_done = 1'b1;
      end else if (item.req_type <= REQ_RESUME && item.slot < NumSlots) begin
         result.request_done = 1'b1;
         case (item.req_type)
            REQ_CREATE: begin
               if (task_present[item.slot]) begin
                  result.request_done = 1'b0;
               end else begin
                  task_period[item.slot]  = item.period;
                  task_present[item.slot] = 1'b1;
                  slot_paused[item.slot]  = 1'b0;
               end
            end
            REQ_DELETE: begin
               task_period[item.slot]  = '0;
               task_present[item.slot] = 1'b0;
               slot_paused[item.slot]  = 1'b0;
            end
            REQ_SUSPEND: begin
               slot_paused[item.slot] = 1'b1;
            end
            default: begin
               slot_paused[item.slot] = 1'b0;
            end
         endcase
      end
      result.tick_count = tick_value;
      return result;
   endfunction

   always @(posedge clock) begin
      rsp_item_type oldest;
      if (reset) begin
         for (int i = 0; i < NumSlots; i++) begin
            task_period[i]  = '0;
            task_present[i] = 1'b0;
            slot_paused[i]  = 1'b0;
         end
         tick_value = '0;
         awaited_rsp.delete();
         outstanding_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               $error("response item arrived with no request outstanding");
               mismatch_count++;
            end else begin
               oldest = awaited_rsp.pop_front();
               if (rsp_data.due_mask !== oldest.due_mask) begin
                  $error("due_mask: expected %0h, got %0h", oldest.due_mask, rsp_data.due_mask);
                  mismatch_count++;
               end
               if (rsp_data.tick_count !== oldest.tick_count) begin
                  $error("tick_count: expected %0d, got %0d",
                         oldest.tick_count, rsp_data.tick_count);
                  mismatch_count++;
               end
               if (rsp_data.request_done !== oldest.request_done) begin
                  $error("request_done: expected %0b, got %0b",
                         oldest.request_done, rsp_data.request_done);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            awaited_rsp.push_back(apply_request(req_data));
         end
         outstanding_count <= awaited_rsp.size();
      end
   end

endmodule

FILE: bench/tb_periodic_task_release_scheduler.sv
// Top of the scheduler testbench: clock, reset, request stimulus, response stalls and verdict.
`timescale 1ns / 1ps
module tb_periodic_task_release_scheduler;
   import ptrs_pkg::*;

   localparam logic [2:0] REQ_UNKNOWN_FIRST = 3'd5;
   localparam logic [2:0] REQ_UNKNOWN_LAST  = 3'd7;
   localparam int         PhaseItems        = 392;
   localparam int         DrainCycles       = 150;

   logic               clock = 1'b0;
   logic               reset;
   int                 idle_pct;
   int                 stall_pct;
   int                 mismatch_count;
   int                 outstanding_count;

   ptrs_req_if req_ch ();
   ptrs_rsp_if rsp_ch ();

   periodic_task_release_scheduler i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   release_schedule_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_data          (req_ch.data),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_data          (rsp_ch.data),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic req_item_type request(input logic [2:0] kind, input logic [7:0] slot,
                                            input logic [PeriodW-1:0] period);
      req_item_type item;
      item.req_type = kind;
      item.slot     = slot;
      item.period   = period;
      return item;
   endfunction

   // mostly well-formed slot traffic with short periods so releases happen often
   function automatic req_item_type random_request();
      req_item_type item;
      int unsigned  pick;
      pick          = $urandom_range(99);
      item.slot     = 8'($urandom_range(NumSlots - 1));
      item.period   = 16'($urandom);
      if (pick < 45) begin
         item.req_type = REQ_TICK;
         item.slot     = 8'($urandom);
      end else if (pick < 65) begin
         item.req_type = REQ_CREATE;
         pick          = $urandom_range(99);
         if (pick < 10) begin
            item.period = '0;
         end else if (pick < 80) begin
            item.period = 16'($urandom_range(1, 12));
         end
      end else if (pick < 77) begin
         item.req_type = REQ_DELETE;
      end else if (pick < 87) begin
         item.req_type = REQ_SUSPEND;
      end else if (pick < 97) begin
         item.req_type = REQ_RESUME;
      end else begin
         item.req_type = 3'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
      end
      if ($urandom_range(99) < 5) begin
         item.slot = 8'($urandom_range(NumSlots, 255));
      end
      return item;
   endfunction

   task automatic send_request(input req_item_type item);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= item;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   initial begin
      req_item_type       directed [$];
      logic [PeriodW-1:0] wrap_periods [8];

      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      idle_pct     = 0;
      stall_pct    = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      directed.push_back(request(REQ_CREATE, 8'd0, 16'd1));
      directed.push_back(request(REQ_CREATE, 8'd1, 16'd0));
      directed.push_back(request(REQ_CREATE, 8'd2, 16'hFFFF));
      directed.push_back(request(REQ_CREATE, 8'd3, 16'd2));
      directed.push_back(request(REQ_CREATE, 8'd0, 16'd5));
      directed.push_back(request(REQ_CREATE, 8'd8, 16'd3));
      directed.push_back(request(REQ_CREATE, 8'hFF, 16'hFFFF));
      directed.push_back(request(REQ_SUSPEND, 8'd3, 16'hFFFF));
      directed.push_back(request(REQ_TICK, 8'hFF, 16'hFFFF));
      directed.push_back(request(REQ_TICK, 8'd0, 16'd0));
      directed.push_back(request(REQ_RESUME, 8'd3, 16'd0));
      directed.push_back(request(REQ_TICK, 8'd0, 16'd0));
      directed.push_back(request(REQ_TICK, 8'd0, 16'd0));
      directed.push_back(request(REQ_SUSPEND, 8'd7, 16'd0));
      directed.push_back(request(REQ_CREATE, 8'd7, 16'd1));
      directed.push_back(request(REQ_RESUME, 8'd6, 16'd0));
      directed.push_back(request(REQ_DELETE, 8'd5, 16'd0));
      directed.push_back(request(REQ_DELETE, 8'd0, 16'd0));
      directed.push_back(request(REQ_TICK, 8'd0, 16'd0));
      for (int k = REQ_UNKNOWN_FIRST; k <= REQ_UNKNOWN_LAST; k++) begin
         directed.push_back(request(3'(k), 8'd0, 16'd1));
      end
      directed.push_back(request(REQ_DELETE, 8'd200, 16'd0));
      directed.push_back(request(REQ_SUSPEND, 8'd9, 16'd0));
      directed.push_back(request(REQ_RESUME, 8'hFF, 16'd0));
      foreach (directed[i]) begin
         send_request(directed[i]);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 70; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 70; end
            default: begin idle_pct = 20; stall_pct = 20; end
         endcase
         for (int n = 0; n < PhaseItems; n++) begin
            send_request(random_request());
         end
      end

      // clear all slots, create them with assorted periods (one zero) and tick under light stalls
      idle_pct  = 0;
      stall_pct = 0;
      for (int s = 0; s < NumSlots; s++) begin
         send_request(request(REQ_DELETE, 8'(s), 16'd0));
      end
      wrap_periods = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd7, 16'hFFFF, 16'd0, 16'd16};
      for (int s = 0; s < NumSlots; s++) begin
         send_request(request(REQ_CREATE, 8'(s), wrap_periods[s % 8]));
      end
      idle_pct  = 20;
      stall_pct = 20;
      repeat (40) begin
         send_request(request(REQ_TICK, 8'd0, 16'd0));
      end

      req_ch.valid <= 1'b0;
      stall_pct = 0;
      @(posedge clock);
      while (outstanding_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (outstanding_count != 0) begin
         $error("%0d expected response items never arrived", outstanding_count);
      end
      if (mismatch_count == 0 && outstanding_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/ptrs_pkg.sv
rtl/core/ptrs_if.sv
rtl/core/periodic_task_release_scheduler.sv
bench/release_schedule_checker.sv
bench/tb_periodic_task_release_scheduler.sv
